// ----- rtl/fixed_pool_free_list_manager_top_macros.svh -----
// Assertion helpers used by the RTL file fpfl_ctrl.sv.
`ifndef FIXED_POOL_FREE_LIST_MANAGER_TOP_MACROS_SVH
`define FIXED_POOL_FREE_LIST_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fpfl_pkg.sv -----
`default_nettype none

package fpfl_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int ITEM_W     = 8;
  localparam int COUNT_W    = 9;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  // Byte address of the item_count register on the config port.
  localparam logic [1:0] ADDR_ITEM_COUNT = 2'd0;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_SORTED  = 3'd2,
    OP_QUERY   = 3'd3,
    OP_INIT    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_WALK,
    S_WALK_WAIT,
    S_INS_LINK,
    S_INS_PREV,
    S_INIT,
    S_DONE
  } state_t;

  // One access slot to the link memory per cycle.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } link_req_t;

endpackage

`default_nettype wire

// ----- rtl/fpfl_link_ram.sv -----
`default_nettype none

module fpfl_link_ram
  import fpfl_pkg::*;
(
  input  wire logic              clk,
  input  wire link_req_t         req,
  output logic      [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [POOL_DEPTH];
  logic [LINK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/fpfl_ctrl.sv -----
`default_nettype none

module fpfl_ctrl
  import fpfl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COUNT_W-1:0] item_count,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [2:0]         in_op,
  input  wire logic [ITEM_W-1:0]  in_item,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [1:0]         out_status,
  output logic      [ITEM_W-1:0]  out_granted,
  output link_req_t               mem_req,
  input  wire logic [LINK_W-1:0]  rd_data
);

  `include "fixed_pool_free_list_manager_top_macros.svh"

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  item_r, item_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic              prev_vld_r, prev_vld_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ITEM_W-1:0] res_granted_r, res_granted_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ITEM_W-1:0] out_granted_r, out_granted_nxt;

  logic [COUNT_W-1:0] live_cnt;
  logic               in_range;
  logic               walk_stop;
  logic               out_free;
  logic               init_last;

  // Count of zero acts as one, anything above the pool as the pool depth.
  always_comb begin
    if (item_count == '0) begin
      live_cnt = COUNT_W'(1);
    end else if (item_count > COUNT_W'(POOL_DEPTH)) begin
      live_cnt = COUNT_W'(POOL_DEPTH);
    end else begin
      live_cnt = item_count;
    end
  end

  assign in_range  = {1'b0, in_item} < live_cnt;
  assign walk_stop = (cur_r >= LINK_NULL) || (steps_r == LINK_NULL);
  assign out_free  = !out_valid_r || out_tready;
  assign init_last = {1'b0, idx_r} == (live_cnt - COUNT_W'(1));

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    item_nxt        = item_r;
    head_nxt        = head_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    prev_vld_nxt    = prev_vld_r;
    steps_nxt       = steps_r;
    idx_nxt         = idx_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    in_tready       = 1'b0;
    mem_req         = '0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt          = op_t'(in_op);
          item_nxt        = in_item;
          res_status_nxt  = ST_OK;
          res_granted_nxt = '0;
          state_nxt       = S_DONE;
          case (op_t'(in_op))
            OP_ALLOC: begin
              if (head_r >= LINK_NULL) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                res_granted_nxt = head_r[ITEM_W-1:0];
                mem_req.re      = 1'b1;
                mem_req.raddr   = head_r[IDX_W-1:0];
                state_nxt       = S_ALLOC_RD;
              end
            end
            OP_RELEASE: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_item;
                mem_req.wdata = head_r;
                head_nxt      = {1'b0, in_item};
              end
            end
            OP_SORTED, OP_QUERY: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                cur_nxt      = head_r;
                prev_vld_nxt = 1'b0;
                steps_nxt    = '0;
                state_nxt    = S_WALK;
              end
            end
            OP_INIT: begin
              idx_nxt   = '0;
              state_nxt = S_INIT;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_ALLOC_RD: begin
        head_nxt  = rd_data;
        state_nxt = S_DONE;
      end

      S_WALK: begin
        if (!walk_stop && cur_r == {1'b0, item_r}) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else if (op_r == OP_QUERY && walk_stop) begin
          res_status_nxt = ST_EMPTY;
          state_nxt      = S_DONE;
        end else if (op_r == OP_SORTED && (walk_stop || cur_r > {1'b0, item_r})) begin
          state_nxt = S_INS_LINK;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cur_r[IDX_W-1:0];
          prev_nxt      = cur_r[IDX_W-1:0];
          prev_vld_nxt  = 1'b1;
          state_nxt     = S_WALK_WAIT;
        end
      end

      S_WALK_WAIT: begin
        cur_nxt   = rd_data;
        steps_nxt = steps_r + LINK_W'(1);
        state_nxt = S_WALK;
      end

      // cur holds the successor of prev (or the head when prev is unset)
      S_INS_LINK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = item_r;
        mem_req.wdata = cur_r;
        if (prev_vld_r) begin
          state_nxt = S_INS_PREV;
        end else begin
          head_nxt  = {1'b0, item_r};
          state_nxt = S_DONE;
        end
      end

      S_INS_PREV: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = prev_r;
        mem_req.wdata = {1'b0, item_r};
        state_nxt     = S_DONE;
      end

      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = init_last ? LINK_NULL : ({1'b0, idx_r} + LINK_W'(1));
        idx_nxt       = idx_r + IDX_W'(1);
        if (init_last) begin
          head_nxt  = '0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_NULL;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    item_r        <= item_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    steps_r       <= steps_nxt;
    idx_r         <= idx_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

  `FPFL_ASSERT_NOW(a_one_mem_access, mem_req.we, !mem_req.re,
                   "link memory read and written in the same cycle")
  `FPFL_ASSERT_NEXT(a_done_loads_out, (state_r == S_DONE) && out_free, out_valid_r,
                    "finished item not moved to the output register")
  `FPFL_ASSERT_NOW(a_grant_only_ok, out_valid_r && (out_status_r != ST_OK),
                   out_granted_r == '0, "granted index set on a failed item")
  `FPFL_ASSERT_NOW(a_walk_bounded, (state_r == S_WALK) || (state_r == S_WALK_WAIT),
                   steps_r <= LINK_NULL, "list walk ran past the pool depth")

endmodule

`default_nettype wire

// ----- rtl/fixed_pool_free_list_manager_top.sv -----
// Channel  Protocol  Payload
// in_*     stream    tdata: operation[2:0], item_index[10:3]
// out_*    stream    tdata: status[1:0], granted_index[9:2]
// cfg_*    APB       item_count at byte address 0
//
// Release, empty allocate, out of range and unknown codes go from idle to done.
// A granting allocate passes S_ALLOC_RD, loading the new head from the link memory.
// Query and sorted release read one link per entry passed; inserts then write links.
// Init writes one link per cycle, chaining the effective count of entries.
// Reset empties the list; links stay unknown until init or release writes them.
// A result waiting on out_tready lets one more item finish; then the input stalls.
`default_nettype none

module fixed_pool_free_list_manager_top
  import fpfl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // operation[2:0], item_index[10:3], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,    // status[1:0], granted_index[9:2], zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [COUNT_W-1:0] item_count_r;
  link_req_t          mem_req;
  logic [LINK_W-1:0]  rd_data;
  logic [1:0]         out_status;
  logic [ITEM_W-1:0]  out_granted;

  // Single register; a write to any address lands in it, reads return it at address 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= COUNT_W'(256);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      item_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_ITEM_COUNT) ?
                      {{(32-COUNT_W){1'b0}}, item_count_r} : '0;

  fpfl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_count  (item_count_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tdata[2:0]),
    .in_item     (in_tdata[10:3]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_status),
    .out_granted (out_granted),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  fpfl_link_ram u_link_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign out_tdata = {6'b0, out_granted, out_status};

endmodule

`default_nettype wire
